@@ sv/db_to_magnitude_clamped_assert.svh @@
// Assertion macros for the dB-to-magnitude converter.
`ifndef DB_TO_MAGNITUDE_CLAMPED_ASSERT_SVH
`define DB_TO_MAGNITUDE_CLAMPED_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dmc_pkg.sv @@
// Constants and types for the dB-to-magnitude converter.
`default_nettype none

package dmc_pkg;

  localparam int DB_FRAC_BITS   = 8;
  localparam int MANT_FRAC_BITS = 15;

  localparam int DB_W      = 18;
  localparam int MANT_W    = 16;
  localparam int EXP_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam int SAT_DB     = 320;
  localparam int SCALE_FRAC = 32;

  localparam int K_W = 30;
  localparam logic [K_W-1:0] K_LOG2_10_OVER_20 = 30'd713378626;
  localparam logic [31:0]    LN2_Q32           = 32'd2977044472;

  localparam int TAYLOR_TERMS = 14;

  localparam int Y_W   = DB_W + K_W + 1;
  localparam int MAG_W = Y_W - 1;
  localparam int TB    = DB_FRAC_BITS + SCALE_FRAC;
  localparam int MH_W  = MAG_W - TB;
  localparam int U_W   = 32;
  localparam int Z_W   = 31;
  localparam int TERM_W = 32;
  localparam int SUM_W = SCALE_FRAC + 1;
  localparam int Q_W   = 32;
  localparam int VAL_W = SUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DB   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DB  = 2'd3;

  typedef logic signed [DB_W-1:0]  db_t;
  typedef logic signed [EXP_W-1:0] exp_t;
  typedef logic [MANT_W-1:0]       mant_t;

  localparam db_t SAT_POS = DB_W'(SAT_DB << DB_FRAC_BITS);
  localparam db_t SAT_NEG = -SAT_POS;

  typedef struct packed {
    logic              valid;
    logic              neg;
    exp_t              e;
    logic [Z_W-1:0]    z;
    logic [TERM_W-1:0] term;
    logic [TERM_W-1:0] x;
    logic [SUM_W-1:0]  sum;
  } tay_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    exp_t             e;
    logic [SUM_W-1:0] den;
    logic [SUM_W-1:0] rem;
    logic [Q_W-1:0]   nlow;
    logic [Q_W-1:0]   quo;
  } div_stage_t;

endpackage

`default_nettype wire

@@ sv/db_to_magnitude_clamped.sv @@
// Pipelined dB-to-magnitude converter: clamp, scale, exp2 by series, reciprocal.
//
// Converts one signed Q.8 dB level per clock into 10^(dB/20) = mantissa * 2^exponent,
// mantissa unsigned Q1.15 in [0.707, 1.415], exponent -53..53. The level is clamped
// to the enabled limits, then held to +-320 dB. Throughput is one transfer per clock
// while the skid register is empty. The pipeline has six front stages (clamp, scale
// multiply, magnitude, rounding, Q32 fraction, ln2 multiply), thirteen series terms
// of three stages each, and a 32-stage restoring divider for negative fractions. An
// output skid register lets the pipeline take one more transfer while a result
// waits; only a full skid register stalls the whole pipeline.
`default_nettype none

`include "db_to_magnitude_clamped_assert.svh"

module db_to_magnitude_clamped (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmc_pkg::DB_W-1:0]       cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [dmc_pkg::DB_W-1:0] in_level_db,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dmc_pkg::MANT_W-1:0]          out_mantissa,
  output logic signed [dmc_pkg::EXP_W-1:0]    out_exponent
);
  import dmc_pkg::*;

  logic low_en_r;
  logic high_en_r;
  db_t  low_db_r;
  db_t  high_db_r;

  logic en;

  logic s1_valid_r;
  db_t  s1_d_r;
  db_t  d_nxt;

  logic                  s2_valid_r;
  logic signed [Y_W-1:0] s2_y_r;
  logic signed [Y_W-1:0] y_nxt;

  logic             s3_valid_r;
  logic             s3_neg_r;
  logic [MAG_W-1:0] s3_mag_r;
  logic signed [Y_W-1:0] y_abs;

  logic            s4_valid_r;
  logic            s4_neg_r;
  exp_t            s4_e_r;
  logic [TB-1:0]   s4_rmag_r;
  logic [MH_W-1:0] mh;
  logic [TB-1:0]   ml;
  logic            half;
  logic [MH_W:0]   emag;
  logic [MH_W:0]   e_full;
  logic [TB-1:0]   rmag_nxt;
  logic            neg_r_nxt;

  logic           s5_valid_r;
  logic           s5_neg_r;
  exp_t           s5_e_r;
  logic [U_W-1:0] s5_u_r;
  logic [TB:0]    u_full;

  logic [2*U_W-1:0] pz;
  tay_t             tay_init;

  tay_t tay_r [1:TAYLOR_TERMS];
  tay_t mul_r [2:TAYLOR_TERMS];
  tay_t rcp_r [2:TAYLOR_TERMS];

  div_stage_t div_init;
  div_stage_t div_src [Q_W];
  div_stage_t div_nxt [Q_W];
  div_stage_t div_r   [Q_W];

  div_stage_t       last;
  logic [VAL_W-1:0] val_pos;
  logic [VAL_W-1:0] val;
  logic [VAL_W-1:0] mant_full;
  logic             up_valid;
  mant_t            up_mant;
  exp_t             up_exp;

  logic  out_valid_r;
  mant_t out_mant_r;
  exp_t  out_exp_r;
  logic  skid_valid_r;
  mant_t skid_mant_r;
  exp_t  skid_exp_r;

  localparam logic [TB:0]      RND_DB  = (TB+1)'(1) << (DB_FRAC_BITS - 1);
  localparam logic [2*U_W-1:0] RND_Z   = (2*U_W)'(1) << (SCALE_FRAC - 1);
  localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << SCALE_FRAC;
  localparam logic [SUM_W-1:0] NUM_HI  = SUM_W'(1) << (Q_W - 1);
  localparam logic [VAL_W-1:0] RND_M   = VAL_W'(1) << (30 - MANT_FRAC_BITS);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_en_r  <= 1'b0;
      high_en_r <= 1'b0;
      low_db_r  <= SAT_NEG;
      high_db_r <= SAT_POS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LOW_EN:  low_en_r  <= cfg_data[0];
        CFG_HIGH_EN: high_en_r <= cfg_data[0];
        CFG_LOW_DB:  low_db_r  <= cfg_data;
        CFG_HIGH_DB: high_db_r <= cfg_data;
        default:     low_en_r  <= low_en_r;
      endcase
    end
  end

  assign en       = !skid_valid_r;
  assign in_ready = en;

  // Stage 1: clamp and saturate.
  always_comb begin
    d_nxt = in_level_db;
    if (low_en_r && d_nxt < low_db_r) begin
      d_nxt = low_db_r;
    end
    if (high_en_r && d_nxt > high_db_r) begin
      d_nxt = high_db_r;
    end
    if (d_nxt > SAT_POS) begin
      d_nxt = SAT_POS;
    end
    if (d_nxt < SAT_NEG) begin
      d_nxt = SAT_NEG;
    end
  end

  // Stage 2: scale by log2(10)/20.
  assign y_nxt = s1_d_r * $signed({1'b0, K_LOG2_10_OVER_20});

  // Stage 3: magnitude.
  assign y_abs = (s2_y_r < 0) ? -s2_y_r : s2_y_r;

  // Stage 4: round to exponent, split off fraction.
  always_comb begin
    mh        = s3_mag_r[MAG_W-1:TB];
    ml        = s3_mag_r[TB-1:0];
    half      = ml[TB-1];
    emag      = {1'b0, mh} + (MH_W+1)'(half);
    e_full    = s3_neg_r ? -emag : emag;
    rmag_nxt  = half ? (~ml + TB'(1)) : ml;
    neg_r_nxt = half ? !s3_neg_r : (s3_neg_r && (ml != '0));
  end

  // Stage 5: fraction to Q32.
  assign u_full = ({1'b0, s4_rmag_r} + RND_DB) >> DB_FRAC_BITS;

  // Stage 6: times ln2, first series term.
  always_comb begin
    pz                = (2*U_W)'(s5_u_r) * (2*U_W)'(LN2_Q32) + RND_Z;
    tay_init.valid    = s5_valid_r;
    tay_init.neg      = s5_neg_r;
    tay_init.e        = s5_e_r;
    tay_init.z        = pz[SCALE_FRAC +: Z_W];
    tay_init.term     = TERM_W'(pz[SCALE_FRAC +: Z_W]);
    tay_init.x        = '0;
    tay_init.sum      = SUM_ONE + SUM_W'(pz[SCALE_FRAC +: Z_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      s2_valid_r      <= 1'b0;
      s3_valid_r      <= 1'b0;
      s4_valid_r      <= 1'b0;
      s5_valid_r      <= 1'b0;
      tay_r[1].valid  <= 1'b0;
    end else if (en) begin
      s1_valid_r      <= in_valid;
      s2_valid_r      <= s1_valid_r;
      s3_valid_r      <= s2_valid_r;
      s4_valid_r      <= s3_valid_r;
      s5_valid_r      <= s4_valid_r;
      tay_r[1]        <= tay_init;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r    <= d_nxt;
      s2_y_r    <= y_nxt;
      s3_neg_r  <= s2_y_r < 0;
      s3_mag_r  <= MAG_W'(y_abs);
      s4_neg_r  <= neg_r_nxt;
      s4_e_r    <= EXP_W'(e_full);
      s4_rmag_r <= rmag_nxt;
      s5_neg_r  <= s4_neg_r;
      s5_e_r    <= s4_e_r;
      s5_u_r    <= U_W'(u_full);
    end
  end

  // Series terms: multiply by z, divide by k via reciprocal, correct and accumulate.
  for (genvar k = 2; k <= TAYLOR_TERMS; k++) begin : g_term
    localparam int unsigned KD = k;
    localparam logic [TERM_W-1:0] RCP = TERM_W'((64'd1 << SCALE_FRAC) / KD);
    localparam logic [TERM_W-1:0] KV  = TERM_W'(KD);

    tay_t                mul_nxt;
    tay_t                rcp_nxt;
    tay_t                acc_nxt;
    logic [2*TERM_W-1:0] tz;
    logic [2*TERM_W-1:0] xr;
    logic [TERM_W-1:0]   qk;
    logic [TERM_W-1:0]   rem;

    always_comb begin
      mul_nxt   = tay_r[k-1];
      tz        = (2*TERM_W)'(tay_r[k-1].term) * (2*TERM_W)'(tay_r[k-1].z);
      mul_nxt.x = tz[SCALE_FRAC +: TERM_W];
    end

    always_comb begin
      rcp_nxt      = mul_r[k];
      xr           = (2*TERM_W)'(mul_r[k].x) * (2*TERM_W)'(RCP);
      rcp_nxt.term = xr[SCALE_FRAC +: TERM_W];
    end

    always_comb begin
      acc_nxt      = rcp_r[k];
      qk           = rcp_r[k].term * KV;
      rem          = rcp_r[k].x - qk;
      acc_nxt.term = rcp_r[k].term + TERM_W'(rem >= KV);
      acc_nxt.sum  = rcp_r[k].sum + SUM_W'(acc_nxt.term);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mul_r[k].valid <= 1'b0;
        rcp_r[k].valid <= 1'b0;
        tay_r[k].valid <= 1'b0;
      end else if (en) begin
        mul_r[k] <= mul_nxt;
        rcp_r[k] <= rcp_nxt;
        tay_r[k] <= acc_nxt;
      end
    end
  end

  // Restoring divider: (2^63 + sum/2) / sum, one quotient bit per stage.
  always_comb begin
    div_init.valid = tay_r[TAYLOR_TERMS].valid;
    div_init.neg   = tay_r[TAYLOR_TERMS].neg;
    div_init.e     = tay_r[TAYLOR_TERMS].e;
    div_init.den   = tay_r[TAYLOR_TERMS].sum;
    div_init.rem   = NUM_HI;
    div_init.nlow  = tay_r[TAYLOR_TERMS].sum[Q_W:1];
    div_init.quo   = '0;
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    logic [SUM_W:0] t;
    logic           ge;

    if (i == 0) begin : g_first
      assign div_src[i] = div_init;
    end else begin : g_rest
      assign div_src[i] = div_r[i-1];
    end

    always_comb begin
      div_nxt[i]      = div_src[i];
      t               = {div_src[i].rem, div_src[i].nlow[Q_W-1]};
      ge              = t >= {1'b0, div_src[i].den};
      div_nxt[i].rem  = ge ? SUM_W'(t - {1'b0, div_src[i].den}) : t[SUM_W-1:0];
      div_nxt[i].nlow = {div_src[i].nlow[Q_W-2:0], 1'b0};
      div_nxt[i].quo  = {div_src[i].quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[i].valid <= 1'b0;
      end else if (en) begin
        div_r[i] <= div_nxt[i];
      end
    end
  end

  // Select path and round to the mantissa.
  always_comb begin
    last      = div_r[Q_W-1];
    val_pos   = VAL_W'(({1'b0, last.den} + (SUM_W+1)'(1)) >> 1);
    val       = last.neg ? VAL_W'(last.quo) : val_pos;
    mant_full = (val + RND_M) >> (31 - MANT_FRAC_BITS);
    up_valid  = last.valid;
    up_mant   = mant_full[MANT_W-1:0];
    up_exp    = last.e;
  end

  // Output register with skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= up_valid;
      end
    end else if (en && up_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_mant_r <= skid_mant_r;
        out_exp_r  <= skid_exp_r;
      end else begin
        out_mant_r <= up_mant;
        out_exp_r  <= up_exp;
      end
    end else if (en) begin
      skid_mant_r <= up_mant;
      skid_exp_r  <= up_exp;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mantissa = out_mant_r;
  assign out_exponent = out_exp_r;

  `DMC_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r, "skid holds data with output empty")
  `DMC_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s1_valid_r, "transfer lost at entry")
  `DMC_ASSERT_NEXT(a_skid_drains, out_valid_r && out_ready && skid_valid_r, out_valid_r && !skid_valid_r, "skid did not drain")
  `DMC_ASSERT_NOW(a_mant_normal, out_valid_r, out_mant_r[15] ^ out_mant_r[14], "mantissa outside range")

endmodule

`default_nettype wire
